// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Request kinds carried on the slave-side tuser.
    typedef enum logic [1:0] {
        FUNC_PUSH_BACK  = 2'd0,
        FUNC_POP_BACK   = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_READ_AT    = 2'd3
    } t_func;

    // Result status carried on the master-side tuser.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Field widths fixed by the stream format.
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POSITION_W = 4;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    // Control word of a transaction waiting for its memory read data.
    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               has_data;
    } t_pend;

endpackage

// ===== design/bounded_deque_with_indexed_read_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_unit
// Bounded double-ended queue with indexed read, held in a ring buffer.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the result side is not stalled,
// and returns one result per request: the entries sit in a single
// synchronous memory whose read data is registered, and a registered
// output stage follows it. The front pointer and the entry count live in
// flip-flops and are updated in the acceptance cycle, so a request sees the
// effect of the one before it without stalls. Requests: push back, pop
// back, pop front, read at a position counted from the front. A push onto a
// full queue is refused with the full status; a pop on an empty queue or a
// read at or past the count returns zero with the empty status. Every result
// reports the count held after its request. Reset does not clear the entries.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read_unit #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] push_value, [35:32] position, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [36:32] entry_count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int unsigned PW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned SW   = CW + 1;
    localparam int unsigned CMPW = (CW > bdq_pkg::POSITION_W) ? CW : bdq_pkg::POSITION_W;
    localparam int unsigned XW   = (CW > bdq_pkg::COUNT_W) ? CW : bdq_pkg::COUNT_W;
    localparam logic [XW-1:0] FULL_EXT = XW'(DEPTH);

    // Entry memory and its registered read port.
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Queue state.
    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // Pipeline control.
    logic            r_p_valid;
    bdq_pkg::t_pend  r_pend, n_pend;
    logic            r_o_valid;
    logic [bdq_pkg::VALUE_W-1:0]  r_o_value;
    bdq_pkg::t_status             r_o_status;
    logic [bdq_pkg::COUNT_W-1:0]  r_o_count;

    logic            w_in_acc;
    logic            w_advance;
    bdq_pkg::t_func  w_func;
    logic [63:0]     w_push_ext;
    logic [DATA_WIDTH-1:0] w_push;
    logic [bdq_pkg::POSITION_W-1:0] w_position;
    logic [CW-1:0]   w_offset;
    logic [PW-1:0]   w_addr;
    logic            w_wr_en;
    logic            w_rd_en;
    logic [63:0]     w_rd_ext;
    logic [XW-1:0]   w_cnt_ext;

    // Ring slot at a given offset from the front, wrapping modulo DEPTH.
    function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] front,
                                                 input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(offset);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    // Field unpacking.
    assign w_func     = bdq_pkg::t_func'(s_axis_tuser);
    assign w_push_ext = {32'd0, s_axis_tdata[31:0]};
    assign w_push     = w_push_ext[DATA_WIDTH-1:0];
    assign w_position = s_axis_tdata[35:32];

    // Handshake: the pending stage moves on whenever the output stage frees.
    assign w_advance     = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || w_advance;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Request decode: next state, memory access and pending control word.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        w_offset = '0;
        w_wr_en  = 1'b0;
        w_rd_en  = 1'b0;
        n_pend.status   = bdq_pkg::STATUS_OK;
        n_pend.has_data = 1'b0;
        unique case (w_func)
            bdq_pkg::FUNC_PUSH_BACK: begin
                w_offset = r_count;
                if (r_count == CW'(DEPTH)) begin
                    n_pend.status = bdq_pkg::STATUS_FULL;
                end else begin
                    w_wr_en = w_in_acc;
                    n_count = r_count + CW'(1);
                end
            end
            bdq_pkg::FUNC_POP_BACK: begin
                w_offset = r_count - CW'(1);
                if (r_count == '0) begin
                    n_pend.status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    w_rd_en         = w_in_acc;
                    n_pend.has_data = 1'b1;
                    n_count         = r_count - CW'(1);
                end
            end
            bdq_pkg::FUNC_POP_FRONT: begin
                w_offset = '0;
                if (r_count == '0) begin
                    n_pend.status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    w_rd_en         = w_in_acc;
                    n_pend.has_data = 1'b1;
                    n_front         = ring_slot(r_front, CW'(1));
                    n_count         = r_count - CW'(1);
                end
            end
            bdq_pkg::FUNC_READ_AT: begin
                w_offset = CW'(w_position);
                if (CMPW'(w_position) >= CMPW'(r_count)) begin
                    n_pend.status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    w_rd_en         = w_in_acc;
                    n_pend.has_data = 1'b1;
                end
            end
            default: begin
                n_pend.status = bdq_pkg::STATUS_EMPTY;
            end
        endcase
        w_cnt_ext    = XW'(n_count);
        n_pend.count = w_cnt_ext[bdq_pkg::COUNT_W-1:0];
    end

    assign w_addr = ring_slot(r_front, w_offset);

    // Entry memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr] <= w_push;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // Queue state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (w_in_acc) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Pending stage: holds the control word while the memory read data comes in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_p_valid <= 1'b1;
        end else if (w_advance) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend <= n_pend;
        end
    end

    assign w_rd_ext = 64'(r_rd_data);

    // Output stage: holds a finished result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_advance) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_o_value  <= r_pend.has_data ? w_rd_ext[bdq_pkg::VALUE_W-1:0] : '0;
            r_o_status <= r_pend.status;
            r_o_count  <= r_pend.count;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'd0, r_o_count, r_o_value};
    assign m_axis_tuser  = r_o_status;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(DEPTH) >= r_count)
        else $error("entry count beyond capacity");

    // The front pointer always names a slot inside the ring.
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(DEPTH - 1) >= r_front)
        else $error("front pointer outside the ring");

    // An accepted push with room grows the count by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_func == bdq_pkg::FUNC_PUSH_BACK && r_count != CW'(DEPTH))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the count");

    // A refused or empty result carries a zero word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != bdq_pkg::STATUS_OK) |-> r_o_value == '0)
        else $error("failed request returned data");

    // A full refusal reports the full count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_pend.status == bdq_pkg::STATUS_FULL)
        |-> r_pend.count == FULL_EXT[bdq_pkg::COUNT_W-1:0])
        else $error("full status with wrong count");

endmodule

// ===== sim/bdq_result_checker.sv =====
// ----------------------------------------------------------------------------
// bdq_result_checker
// Watches both stream channels of the bounded deque, predicts every result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bdq_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel as seen by the block.
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [bdq_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [31:0] push_value, [35:32] position
    input  logic [1:0]                     i_s_tuser,   // [1:0] func
    // Result channel as seen by the block.
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [bdq_pkg::OUT_DATA_W-1:0] i_m_tdata,   // [31:0] result_value, [36:32] entry_count
    input  logic [1:0]                     i_m_tuser,   // [1:0] status
    // Running totals for the testbench top.
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS      = 16;
    localparam int unsigned VALUE_W    = bdq_pkg::VALUE_W;
    localparam int unsigned POSITION_W = bdq_pkg::POSITION_W;
    localparam int unsigned COUNT_W    = bdq_pkg::COUNT_W;

    // One result of the deque, as it travels on the result channel.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        bdq_pkg::t_status   status;
        logic [COUNT_W-1:0] count;
    } t_result;

    // Shadow copy of the ring buffer and its pointers.
    logic [VALUE_W-1:0]    ring [SLOTS];
    logic [POSITION_W-1:0] front_idx;
    logic [COUNT_W-1:0]    held;

    // Results predicted but not yet returned, oldest first.
    t_result results_due [$];
    int      fail_total = 0;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
        fail_total++;
    endtask

    // Applies one request to the shadow deque and returns the result it gives.
    // Ring indexes are four bits wide, so every slot sum wraps around the ring.
    task automatic deque_step(input bdq_pkg::t_func f, input logic [VALUE_W-1:0] v,
                              input logic [POSITION_W-1:0] p, output t_result r);
        logic [POSITION_W-1:0] slot;
        r.value  = '0;
        r.status = bdq_pkg::STATUS_OK;
        case (f)
            bdq_pkg::FUNC_PUSH_BACK: begin
                if (held == COUNT_W'(SLOTS)) begin
                    r.status = bdq_pkg::STATUS_FULL;
                end else begin
                    slot       = front_idx + held[POSITION_W-1:0];
                    ring[slot] = v;
                    held       = held + COUNT_W'(1);
                end
            end
            bdq_pkg::FUNC_POP_BACK: begin
                if (held == '0) begin
                    r.status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    slot    = front_idx + held[POSITION_W-1:0] - POSITION_W'(1);
                    r.value = ring[slot];
                    held    = held - COUNT_W'(1);
                end
            end
            bdq_pkg::FUNC_POP_FRONT: begin
                if (held == '0) begin
                    r.status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    r.value   = ring[front_idx];
                    front_idx = front_idx + POSITION_W'(1);
                    held      = held - COUNT_W'(1);
                end
            end
            default: begin
                // Indexed read: only positions below the count are valid.
                if ({1'b0, p} >= held) begin
                    r.status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    slot    = front_idx + p;
                    r.value = ring[slot];
                end
            end
        endcase
        r.count = held;
    endtask

    // Results are checked before requests are predicted, so that a result is
    // never paired with a request accepted on the same edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            front_idx = '0;
            held      = '0;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.value  = i_m_tdata[VALUE_W-1:0];
                got.count  = i_m_tdata[VALUE_W +: COUNT_W];
                got.status = bdq_pkg::t_status'(i_m_tuser);
                if (results_due.size() == 0) begin
                    report_mismatch("result transaction with nothing due", 64'(got), 64'd0);
                end else begin
                    want = results_due.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("result_value", 64'(got.value), 64'(want.value));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 64'(got.count), 64'(want.count));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                deque_step(bdq_pkg::t_func'(i_s_tuser), i_s_tdata[VALUE_W-1:0],
                           i_s_tdata[VALUE_W +: POSITION_W], want);
                results_due.push_back(want);
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== sim/tb_bounded_deque_with_indexed_read_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_indexed_read_unit
// Stimulus and verdict for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
// A directed opening covers the empty and full corners and the extreme data
// and position values; bursts of random requests follow, each burst leaning
// toward filling, draining, mixing or reading. Both channels idle at random,
// the result side twice holds off long enough to stall the request side, and
// the request side pauses until every result is back. Checking is done by
// the checker instance.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_indexed_read_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 400000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 8;

    localparam int unsigned VALUE_W    = bdq_pkg::VALUE_W;
    localparam int unsigned POSITION_W = bdq_pkg::POSITION_W;
    localparam int unsigned IN_DATA_W  = bdq_pkg::IN_DATA_W;
    localparam int unsigned OUT_DATA_W = bdq_pkg::OUT_DATA_W;

    // Burst flavors for the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_READS
    } t_mix;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = bdq_pkg::FUNC_PUSH_BACK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int fail_count;
    int pending;
    int send_calm;
    int sink_calm;
    int hold_reqs;
    int holds_done;

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bounded_deque_with_indexed_read_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bdq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle length: mostly none, some short, a few long, with calm stretches.
    function automatic int idle_len(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one request, waits for its transaction, then idles at random.
    task automatic send_request(input bdq_pkg::t_func f, input logic [VALUE_W-1:0] v,
                                input logic [POSITION_W-1:0] p);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {{(IN_DATA_W - VALUE_W - POSITION_W){1'b0}}, p, v};
        do @(posedge i_clk); while (!s_axis_tready);
        gap = idle_len(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Request kind weighted by the burst flavor.
    function automatic bdq_pkg::t_func pick_func(input t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (roll < 70) return bdq_pkg::FUNC_PUSH_BACK;
                if (roll < 78) return bdq_pkg::FUNC_POP_BACK;
                if (roll < 86) return bdq_pkg::FUNC_POP_FRONT;
            end
            MIX_DRAIN: begin
                if (roll < 20) return bdq_pkg::FUNC_PUSH_BACK;
                if (roll < 55) return bdq_pkg::FUNC_POP_BACK;
                if (roll < 85) return bdq_pkg::FUNC_POP_FRONT;
            end
            MIX_EVEN: begin
                if (roll < 25) return bdq_pkg::FUNC_PUSH_BACK;
                if (roll < 50) return bdq_pkg::FUNC_POP_BACK;
                if (roll < 75) return bdq_pkg::FUNC_POP_FRONT;
            end
            default: begin
                if (roll < 25) return bdq_pkg::FUNC_PUSH_BACK;
                if (roll < 30) return bdq_pkg::FUNC_POP_BACK;
                if (roll < 35) return bdq_pkg::FUNC_POP_FRONT;
            end
        endcase
        return bdq_pkg::FUNC_READ_AT;
    endfunction

    // Data word with extra weight on all zeros and all ones.
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 16) return '1;
        return $urandom;
    endfunction

    // Result side: random stalls, plus one long hold-off per request for one.
    initial begin : result_sink
        int stall;
        sink_calm  = 0;
        holds_done = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = idle_len(sink_calm);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Ends the run if it takes far longer than any correct run could.
    initial begin : run_watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[bounded_deque_with_indexed_read_unit] ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : request_source
        int   sent;
        int   burst;
        int   burst_no;
        t_mix mix;
        send_calm = 0;
        hold_reqs = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: both pops and reads at the lowest and highest positions.
        send_request(bdq_pkg::FUNC_POP_BACK, 32'h1234_5678, 4'd0);
        send_request(bdq_pkg::FUNC_POP_FRONT, 32'h8765_4321, 4'd0);
        send_request(bdq_pkg::FUNC_READ_AT, 32'h0, 4'd0);
        send_request(bdq_pkg::FUNC_READ_AT, 32'hFFFF_FFFF, 4'd15);
        // Extreme data words, then fill the ring to its last slot.
        send_request(bdq_pkg::FUNC_PUSH_BACK, 32'h0000_0000, 4'd15);
        send_request(bdq_pkg::FUNC_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
        send_request(bdq_pkg::FUNC_READ_AT, 32'h0, 4'd1);
        repeat (14) send_request(bdq_pkg::FUNC_PUSH_BACK, $urandom,
                                 4'($urandom_range(0, 15)));
        // Full queue refuses the push; the last position is readable.
        send_request(bdq_pkg::FUNC_PUSH_BACK, 32'hA5A5_5A5A, 4'd0);
        send_request(bdq_pkg::FUNC_READ_AT, 32'h0, 4'd15);
        send_request(bdq_pkg::FUNC_POP_BACK, 32'h0, 4'd0);
        send_request(bdq_pkg::FUNC_POP_FRONT, 32'h0, 4'd0);
        // Two entries short of full, so the last position is now out of range.
        send_request(bdq_pkg::FUNC_READ_AT, 32'h0, 4'd15);
        wait_results_drained();

        // Random bursts; the result side holds off at the start and midway.
        hold_reqs++;
        sent     = 0;
        burst_no = 0;
        while (sent < RANDOM_ITEMS) begin
            mix   = t_mix'($urandom_range(0, 3));
            burst = $urandom_range(15, 60);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                send_request(pick_func(mix), pick_value(),
                             ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(0, 3)));
                sent++;
            end
            burst_no++;
            if (burst_no == 8) hold_reqs++;
            if (burst_no == 4 || $urandom_range(0, 7) == 0) wait_results_drained();
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[bounded_deque_with_indexed_read_unit] OK");
        end else begin
            $display("[bounded_deque_with_indexed_read_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bdq_pkg.sv
design/bounded_deque_with_indexed_read_unit.sv
sim/bdq_result_checker.sv
sim/tb_bounded_deque_with_indexed_read_unit.sv
